// File: hw/rtl/qrr_pkg.sv
// qrr_pkg: shared types, register codes and fixed-point helpers for the
// quaternion to rotation remap unit. No dependencies.
package qrr_pkg;

	typedef logic signed [15:0] q14_t;   // signed Q1.14
	typedef logic signed [31:0] prod_t;  // exact Q2.28 product
	typedef logic signed [35:0] acc_t;   // Q2.28 sums with headroom

	typedef struct packed {
		q14_t c0;
		q14_t c1;
		q14_t c2;
	} row_t;

	typedef struct packed {
		row_t r0;
		row_t r1;
		row_t r2;
	} mat_t;

	// register indexes on the configuration port
	localparam logic CFG_SENSOR_ENABLE    = 1'b0;
	localparam logic CFG_DISPLAY_ROTATION = 1'b1;

	// display rotation codes
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	localparam acc_t ONE_Q28  = 36'sh010000000;
	localparam acc_t HALF_Q14 = 36'sh000002000;
	localparam acc_t Q14_MAX  = 36'sh000007fff;
	localparam acc_t Q14_MIN  = -36'sh000008000;

	// register stages between input and output transfer
	localparam int PIPE_DEPTH = 5;

	// Q2.28 to Q1.14, round half up, saturate
	function automatic q14_t to_q14(input acc_t v);
		acc_t t;
		t = (v + HALF_Q14) >>> 14;
		if (t > Q14_MAX) begin
			to_q14 = 16'sh7fff;
		end else if (t < Q14_MIN) begin
			to_q14 = 16'sh8000;
		end else begin
			to_q14 = q14_t'(t[15:0]);
		end
	endfunction

	// negate with -(-2.0) clamped to the largest positive value
	function automatic q14_t neg_sat(input q14_t v);
		if (v == 16'sh8000) begin
			neg_sat = 16'sh7fff;
		end else begin
			neg_sat = -v;
		end
	endfunction

endpackage

// File: hw/rtl/qrr_matrix.sv
// qrr_matrix: quaternion to 3x3 rotation matrix, two register stages
// (products, then sums with rounding). Depends on qrr_pkg.
module qrr_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qrr_pkg::q14_t      quat_x,
	input  qrr_pkg::q14_t      quat_y,
	input  qrr_pkg::q14_t      quat_z,
	input  qrr_pkg::q14_t      quat_w,
	output logic               out_valid,
	input  logic               out_ready,
	output qrr_pkg::mat_t      out_mat
);

	logic v_s1, v_s2;
	logic rdy_s1, rdy_s2;
	qrr_pkg::prod_t xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	qrr_pkg::mat_t  mat_s2;
	qrr_pkg::acc_t  e00, e01, e02, e10, e11, e12, e20, e21, e22;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			xy_s1 <= quat_x * quat_y;
			xz_s1 <= quat_x * quat_z;
			yz_s1 <= quat_y * quat_z;
			wx_s1 <= quat_w * quat_x;
			wy_s1 <= quat_w * quat_y;
			wz_s1 <= quat_w * quat_z;
		end
	end

	// element sums, exact in Q2.28
	always_comb begin
		e00 = qrr_pkg::ONE_Q28 - ((qrr_pkg::acc_t'(yy_s1) + qrr_pkg::acc_t'(zz_s1)) <<< 1);
		e01 = (qrr_pkg::acc_t'(xy_s1) + qrr_pkg::acc_t'(wz_s1)) <<< 1;
		e02 = (qrr_pkg::acc_t'(xz_s1) - qrr_pkg::acc_t'(wy_s1)) <<< 1;
		e10 = (qrr_pkg::acc_t'(xy_s1) - qrr_pkg::acc_t'(wz_s1)) <<< 1;
		e11 = qrr_pkg::ONE_Q28 - ((qrr_pkg::acc_t'(xx_s1) + qrr_pkg::acc_t'(zz_s1)) <<< 1);
		e12 = (qrr_pkg::acc_t'(yz_s1) + qrr_pkg::acc_t'(wx_s1)) <<< 1;
		e20 = (qrr_pkg::acc_t'(xz_s1) + qrr_pkg::acc_t'(wy_s1)) <<< 1;
		e21 = (qrr_pkg::acc_t'(yz_s1) - qrr_pkg::acc_t'(wx_s1)) <<< 1;
		e22 = qrr_pkg::ONE_Q28 - ((qrr_pkg::acc_t'(xx_s1) + qrr_pkg::acc_t'(yy_s1)) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			mat_s2.r0.c0 <= qrr_pkg::to_q14(e00);
			mat_s2.r0.c1 <= qrr_pkg::to_q14(e01);
			mat_s2.r0.c2 <= qrr_pkg::to_q14(e02);
			mat_s2.r1.c0 <= qrr_pkg::to_q14(e10);
			mat_s2.r1.c1 <= qrr_pkg::to_q14(e11);
			mat_s2.r1.c2 <= qrr_pkg::to_q14(e12);
			mat_s2.r2.c0 <= qrr_pkg::to_q14(e20);
			mat_s2.r2.c1 <= qrr_pkg::to_q14(e21);
			mat_s2.r2.c2 <= qrr_pkg::to_q14(e22);
		end
	end

	assign out_valid = v_s2;
	assign out_mat   = mat_s2;

endmodule

// File: hw/rtl/qrr_remap.sv
// qrr_remap: display rotation of rows 0 and 1 and, for any rotation but ROT_0, cross product for row 2,
// three register stages, the last one is the output register. Depends on qrr_pkg.
module qrr_remap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         rotation,
	input  logic               in_valid,
	output logic               in_ready,
	input  qrr_pkg::mat_t      in_mat,
	output logic               out_valid,
	input  logic               out_ready,
	output qrr_pkg::mat_t      out_mat
);

	logic v_s3, v_s4, v_s5;
	logic rdy_s3, rdy_s4, rdy_s5;
	qrr_pkg::row_t  r0_nxt, r1_nxt;
	qrr_pkg::mat_t  mat_s3, mat_s4, mat_s5;
	qrr_pkg::prod_t p0_s4, p1_s4, p2_s4, p3_s4, p4_s4, p5_s4;
	qrr_pkg::row_t  r2_nxt;

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= in_valid;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_comb begin
		unique case (rotation)
			qrr_pkg::ROT_90: begin
				r0_nxt = in_mat.r1;
				r1_nxt.c0 = qrr_pkg::neg_sat(in_mat.r0.c0);
				r1_nxt.c1 = qrr_pkg::neg_sat(in_mat.r0.c1);
				r1_nxt.c2 = qrr_pkg::neg_sat(in_mat.r0.c2);
			end
			qrr_pkg::ROT_180: begin
				r0_nxt.c0 = qrr_pkg::neg_sat(in_mat.r0.c0);
				r0_nxt.c1 = qrr_pkg::neg_sat(in_mat.r0.c1);
				r0_nxt.c2 = qrr_pkg::neg_sat(in_mat.r0.c2);
				r1_nxt.c0 = qrr_pkg::neg_sat(in_mat.r1.c0);
				r1_nxt.c1 = qrr_pkg::neg_sat(in_mat.r1.c1);
				r1_nxt.c2 = qrr_pkg::neg_sat(in_mat.r1.c2);
			end
			qrr_pkg::ROT_270: begin
				r0_nxt.c0 = qrr_pkg::neg_sat(in_mat.r1.c0);
				r0_nxt.c1 = qrr_pkg::neg_sat(in_mat.r1.c1);
				r0_nxt.c2 = qrr_pkg::neg_sat(in_mat.r1.c2);
				r1_nxt = in_mat.r0;
			end
			qrr_pkg::ROT_0: begin
				r0_nxt = in_mat.r0;
				r1_nxt = in_mat.r1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			mat_s3.r0 <= r0_nxt;
			mat_s3.r1 <= r1_nxt;
			mat_s3.r2 <= in_mat.r2;
		end
	end

	// cross product partial terms
	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			mat_s4 <= mat_s3;
			p0_s4  <= mat_s3.r0.c1 * mat_s3.r1.c2;
			p1_s4  <= mat_s3.r0.c2 * mat_s3.r1.c1;
			p2_s4  <= mat_s3.r0.c2 * mat_s3.r1.c0;
			p3_s4  <= mat_s3.r0.c0 * mat_s3.r1.c2;
			p4_s4  <= mat_s3.r0.c0 * mat_s3.r1.c1;
			p5_s4  <= mat_s3.r0.c1 * mat_s3.r1.c0;
		end
	end

	always_comb begin
		if (rotation == qrr_pkg::ROT_0) begin
			r2_nxt = mat_s4.r2;
		end else begin
			r2_nxt.c0 = qrr_pkg::to_q14(qrr_pkg::acc_t'(p0_s4) - qrr_pkg::acc_t'(p1_s4));
			r2_nxt.c1 = qrr_pkg::to_q14(qrr_pkg::acc_t'(p2_s4) - qrr_pkg::acc_t'(p3_s4));
			r2_nxt.c2 = qrr_pkg::to_q14(qrr_pkg::acc_t'(p4_s4) - qrr_pkg::acc_t'(p5_s4));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			mat_s5.r0 <= mat_s4.r0;
			mat_s5.r1 <= mat_s4.r1;
			mat_s5.r2 <= r2_nxt;
		end
	end

	assign out_valid = v_s5;
	assign out_mat   = mat_s5;

endmodule

// File: hw/rtl/quaternion_to_rotation_remap_unit.sv
// quaternion_to_rotation_remap_unit: top level, stream ports, configuration
// registers. Depends on qrr_pkg, qrr_matrix and qrr_remap.
//
// Takes one quaternion (x, y, z, w, signed Q1.14) per transfer and returns the
// 3x3 rotation matrix, rotated for the display orientation, as nine saturated
// Q1.14 elements. The pipeline has five register stages: products, sums with
// rounding, row remap, cross-product terms, and the output register. One
// quaternion can be taken every cycle while the output side keeps up, and a
// stalled output fills the stages before s_tready drops. While sensor_enable
// is zero input transfers still complete but produce no output. Configuration
// must be written only while no transfer is in flight.
module quaternion_to_rotation_remap_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
	input  logic         cfg_wr_en,
	input  logic         cfg_index,
	input  logic [1:0]   cfg_wdata
);

	logic          enable_q;
	logic [1:0]    rotation_q;
	logic          mtx_valid, mtx_ready;
	qrr_pkg::mat_t mtx_mat, res_mat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			rotation_q <= qrr_pkg::ROT_0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				qrr_pkg::CFG_SENSOR_ENABLE:    enable_q   <= cfg_wdata[0];
				qrr_pkg::CFG_DISPLAY_ROTATION: rotation_q <= cfg_wdata;
			endcase
		end
	end

	qrr_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid && enable_q),
		.in_ready  (s_tready),
		.quat_x    (qrr_pkg::q14_t'(s_tdata[15:0])),
		.quat_y    (qrr_pkg::q14_t'(s_tdata[31:16])),
		.quat_z    (qrr_pkg::q14_t'(s_tdata[47:32])),
		.quat_w    (qrr_pkg::q14_t'(s_tdata[63:48])),
		.out_valid (mtx_valid),
		.out_ready (mtx_ready),
		.out_mat   (mtx_mat)
	);

	qrr_remap u_remap (
		.clk       (clk),
		.arst_n    (arst_n),
		.rotation  (rotation_q),
		.in_valid  (mtx_valid),
		.in_ready  (mtx_ready),
		.in_mat    (mtx_mat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_mat   (res_mat)
	);

	assign m_tdata = {res_mat.r2.c2, res_mat.r2.c1, res_mat.r2.c0,
	                  res_mat.r1.c2, res_mat.r1.c1, res_mat.r1.c0,
	                  res_mat.r0.c2, res_mat.r0.c1, res_mat.r0.c0};

endmodule

// File: hw/rtl/qrr_checker.sv
// qrr_checker: port-level assertions for quaternion_to_rotation_remap_unit,
// bound to the top level below. Depends on qrr_pkg.
module qrr_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata,
	input logic         cfg_wr_en,
	input logic         cfg_index,
	input logic [1:0]   cfg_wdata
);

	logic       en_q;
	logic [2:0] pend_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = s_tvalid && s_tready && en_q;
	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			pend_q <= 3'd0;
		end else begin
			if (cfg_wr_en && cfg_index == qrr_pkg::CFG_SENSOR_ENABLE) en_q <= cfg_wdata[0];
			pend_q <= pend_q + 3'(in_xfer) - 3'(out_xfer);
		end
	end

	// a result only for an enabled input still owed
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 3'd0)
		else $error("output valid with no pending input");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'(qrr_pkg::PIPE_DEPTH))
		else $error("more items in flight than pipeline stages");

	// empty output register means every stage can move
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output is empty");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output changed");

endmodule

bind quaternion_to_rotation_remap_unit qrr_checker u_qrr_checker (.*);
